// File: src/lstc_pkg.sv
package lstc_pkg;

    // Widest slot index the chain supports (64 entries).
    localparam int SLOT_IDX_W = 6;
    localparam int KEY_W      = 64;
    localparam int WID_W      = 9;
    localparam int HGT_W      = 8;

    localparam logic [WID_W-1:0] MAX_WID = 9'd256;
    localparam logic [HGT_W-1:0] MAX_HGT = 8'd192;

    localparam logic [2:0] OP_LOOKUP     = 3'd0;
    localparam logic [2:0] OP_REQUEST    = 3'd1;
    localparam logic [2:0] OP_FILL       = 3'd2;
    localparam logic [2:0] OP_UNLOCK     = 3'd3;
    localparam logic [2:0] OP_UNLOCK_ALL = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Request token travelling down the cell chain, with the running results.
    typedef struct packed {
        logic                  live;
        logic [2:0]            op;
        logic [KEY_W-1:0]      key;
        logic [3:0]            slot;
        logic [WID_W-1:0]      wid;
        logic [HGT_W-1:0]      hgt;
        logic                  heap_big;
        logic                  found;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic [WID_W-1:0]      hit_wid;
        logic [HGT_W-1:0]      hit_hgt;
        logic                  lo_found;
        logic [SLOT_IDX_W-1:0] lo_idx;
        logic                  hi_found;
        logic [SLOT_IDX_W-1:0] hi_idx;
    } tok_t;

    // Lock grant broadcast back to the cells.
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] idx;
    } commit_t;

endpackage

// File: src/lstc_cell.sv
module lstc_cell #(
    parameter int CACHE_ENTRIES = 16,
    parameter int CELL_IDX      = 0,
    localparam int IDX_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lstc_pkg::tok_t     tok_in,
    output lstc_pkg::tok_t     tok_out,
    input  logic [IDX_W-1:0]   cursor,
    input  lstc_pkg::commit_t  commit
);

    localparam int IW = lstc_pkg::SLOT_IDX_W;
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    lstc_pkg::tok_t tok_reg, tok_next;

    logic [lstc_pkg::KEY_W-1:0] key_reg, key_next;
    logic                       valid_reg, valid_next;
    logic                       locked_reg, locked_next;
    logic [lstc_pkg::WID_W-1:0] wid_reg, wid_next;
    logic [lstc_pkg::HGT_W-1:0] hgt_reg, hgt_next;

    logic slot_match;

    assign slot_match = (IW'(tok_in.slot) == MY_IDX);
    assign tok_out    = tok_reg;

    always_comb begin
        tok_next    = tok_in;
        key_next    = key_reg;
        valid_next  = valid_reg;
        locked_next = locked_reg;
        wid_next    = wid_reg;
        hgt_next    = hgt_reg;
        if (tok_in.live) begin
            case (tok_in.op)
                lstc_pkg::OP_LOOKUP: begin
                    if (!tok_in.found && valid_reg && key_reg == tok_in.key) begin
                        tok_next.found   = 1'b1;
                        tok_next.hit_idx = MY_IDX;
                        tok_next.hit_wid = wid_reg;
                        tok_next.hit_hgt = hgt_reg;
                    end
                end
                lstc_pkg::OP_REQUEST: begin
                    if (!locked_reg) begin
                        if (!tok_in.lo_found) begin
                            tok_next.lo_found = 1'b1;
                            tok_next.lo_idx   = MY_IDX;
                        end
                        if (!tok_in.hi_found && MY_IDX >= IW'(cursor)) begin
                            tok_next.hi_found = 1'b1;
                            tok_next.hi_idx   = MY_IDX;
                        end
                    end
                end
                lstc_pkg::OP_FILL: begin
                    if (slot_match) begin
                        key_next   = tok_in.key;
                        wid_next   = tok_in.wid;
                        hgt_next   = tok_in.hgt;
                        valid_next = 1'b1;
                    end
                end
                lstc_pkg::OP_UNLOCK: begin
                    if (slot_match) begin
                        locked_next = 1'b0;
                    end
                end
                lstc_pkg::OP_UNLOCK_ALL: begin
                    locked_next = 1'b0;
                end
                lstc_pkg::OP_CLEAR: begin
                    valid_next  = 1'b0;
                    locked_next = 1'b0;
                    wid_next    = '0;
                    hgt_next    = '0;
                end
                default: begin
                end
            endcase
        end
        // grant arrives after the token has left the chain
        if (commit.en && commit.idx == MY_IDX) begin
            locked_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= '0;
            valid_reg  <= 1'b0;
            locked_reg <= 1'b0;
            wid_reg    <= '0;
            hgt_reg    <= '0;
        end else begin
            tok_reg    <= tok_next;
            valid_reg  <= valid_next;
            locked_reg <= locked_next;
            wid_reg    <= wid_next;
            hgt_reg    <= hgt_next;
        end
    end

    // tag store is payload only; valid gates every compare
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// File: src/locked_slot_tag_cache_top.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_op, s_key, s_slot_in, s_img_width, s_img_height,
//                                   s_heap_too_large
// m_        out  m_valid/m_ready    m_hit, m_slot_out, m_out_width, m_out_height
//
// Every request walks the row of entry cells, one cell per cycle, before its
// result shows on m_. The next request is taken once that result sits in
// the output register. Synchronous active-low reset clears valid, lock and
// dimensions of every entry and the round-robin cursor; tags are not reset.
// A stalled result parks in a holding register until m_ready frees the output.
module locked_slot_tag_cache_top #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [63:0] s_key,
    input  logic [3:0]  s_slot_in,
    input  logic [8:0]  s_img_width,
    input  logic [7:0]  s_img_height,
    input  logic        s_heap_too_large,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [3:0]  m_slot_out,
    output logic [8:0]  m_out_width,
    output logic [7:0]  m_out_height
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int IW    = lstc_pkg::SLOT_IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,  // ready for a request
        ST_RUN  = 3'b010,  // token in the cell row
        ST_HOLD = 3'b100   // result waiting for the output register
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0] cursor_reg, cursor_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_hit_reg, m_hit_next;
    logic [3:0] m_slot_reg, m_slot_next;
    logic [8:0] m_wid_reg, m_wid_next;
    logic [7:0] m_hgt_reg, m_hgt_next;

    logic       pend_hit_reg, pend_hit_next;
    logic [3:0] pend_slot_reg, pend_slot_next;
    logic [8:0] pend_wid_reg, pend_wid_next;
    logic [7:0] pend_hgt_reg, pend_hgt_next;

    lstc_pkg::tok_t    chain_tok [CACHE_ENTRIES+1];
    lstc_pkg::tok_t    tail;
    lstc_pkg::commit_t commit;

    logic          out_free;
    logic          grant_ok;
    logic [IW-1:0] grant_idx;
    logic [IDX_W-1:0] grant_cur;
    logic          res_hit;
    logic [3:0]    res_slot;
    logic [8:0]    res_wid;
    logic [7:0]    res_hgt;

    assign s_ready = (state_reg == ST_IDLE);

    // head of the chain: fresh token with clamped dimensions
    always_comb begin
        chain_tok[0]          = '0;
        chain_tok[0].live     = s_valid && s_ready;
        chain_tok[0].op       = s_op;
        chain_tok[0].key      = s_key;
        chain_tok[0].slot     = s_slot_in;
        chain_tok[0].wid      = (s_img_width > lstc_pkg::MAX_WID) ? lstc_pkg::MAX_WID
                                                                  : s_img_width;
        chain_tok[0].hgt      = (s_img_height > lstc_pkg::MAX_HGT) ? lstc_pkg::MAX_HGT
                                                                   : s_img_height;
        chain_tok[0].heap_big = s_heap_too_large;
    end

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        lstc_cell #(
            .CACHE_ENTRIES(CACHE_ENTRIES),
            .CELL_IDX     (g)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .tok_in (chain_tok[g]),
            .tok_out(chain_tok[g+1]),
            .cursor (cursor_reg),
            .commit (commit)
        );
    end

    assign tail = chain_tok[CACHE_ENTRIES];

    // Round robin: first unlocked slot at or past the cursor, else the
    // first unlocked slot from the bottom.
    assign grant_ok  = (tail.op == lstc_pkg::OP_REQUEST) && !tail.heap_big
                       && (tail.hi_found || tail.lo_found);
    assign grant_idx = tail.hi_found ? tail.hi_idx : tail.lo_idx;
    assign grant_cur = IDX_W'(grant_idx);

    assign commit.en  = (state_reg == ST_RUN) && tail.live && grant_ok;
    assign commit.idx = grant_idx;

    always_comb begin
        res_hit  = 1'b0;
        res_slot = '0;
        res_wid  = '0;
        res_hgt  = '0;
        if (tail.op == lstc_pkg::OP_LOOKUP && tail.found) begin
            res_hit  = 1'b1;
            res_slot = tail.hit_idx[3:0];
            res_wid  = tail.hit_wid;
            res_hgt  = tail.hit_hgt;
        end else if (grant_ok) begin
            res_hit  = 1'b1;
            res_slot = grant_idx[3:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_hit_next     = m_hit_reg;
        m_slot_next    = m_slot_reg;
        m_wid_next     = m_wid_reg;
        m_hgt_next     = m_hgt_reg;
        pend_hit_next  = pend_hit_reg;
        pend_slot_next = pend_slot_reg;
        pend_wid_next  = pend_wid_reg;
        pend_hgt_next  = pend_hgt_reg;
        if (commit.en) begin
            cursor_next = (grant_cur == LAST_IDX) ? '0 : grant_cur + IDX_W'(1);
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (tail.live) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_hit_next   = res_hit;
                        m_slot_next  = res_slot;
                        m_wid_next   = res_wid;
                        m_hgt_next   = res_hgt;
                        state_next   = ST_IDLE;
                    end else begin
                        pend_hit_next  = res_hit;
                        pend_slot_next = res_slot;
                        pend_wid_next  = res_wid;
                        pend_hgt_next  = res_hgt;
                        state_next     = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = pend_hit_reg;
                    m_slot_next  = pend_slot_reg;
                    m_wid_next   = pend_wid_reg;
                    m_hgt_next   = pend_hgt_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hit_reg     <= m_hit_next;
        m_slot_reg    <= m_slot_next;
        m_wid_reg     <= m_wid_next;
        m_hgt_reg     <= m_hgt_next;
        pend_hit_reg  <= pend_hit_next;
        pend_slot_reg <= pend_slot_next;
        pend_wid_reg  <= pend_wid_next;
        pend_hgt_reg  <= pend_hgt_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_slot_out   = m_slot_reg;
    assign m_out_width  = m_wid_reg;
    assign m_out_height = m_hgt_reg;

    // cursor never points past the last entry
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= LAST_IDX)
        else $error("cursor out of range");

    // a token leaves the chain only while a request is in flight
    a_tail_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.live |-> state_reg == ST_RUN)
        else $error("token at chain end outside run state");

    // a lock grant moves the cursor one past the granted slot
    a_grant_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        commit.en |=> cursor_reg == (($past(grant_cur) == LAST_IDX) ? '0
                                      : $past(grant_cur) + IDX_W'(1)))
        else $error("cursor not advanced past grant");

    // a result only appears when the chain or the holding register delivers
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RUN || $past(state_reg) == ST_HOLD)
        else $error("result without a finished request");

endmodule
